// ===== hdl/chsi_pkg.sv =====
package chsi_pkg;

    localparam int BUCKETS   = 256;
    localparam int ENTRIES   = 1024;
    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int INODE_W   = 64;
    localparam int DEVICE_W  = 32;
    localparam int BCNT_W    = 9;
    localparam int LIMIT_W   = 11;
    localparam int USED_W    = 11;
    localparam int CFG_W     = 11;
    localparam int MOD_STEP  = 8;
    localparam int MOD_CYC   = INODE_W / MOD_STEP;
    localparam int MCNT_W    = $clog2(MOD_CYC);

    typedef enum logic [0:0] {
        CFG_BUCKET_COUNT = 1'b0,
        CFG_ENTRY_LIMIT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_NEW     = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [INODE_W-1:0]  inode;
        logic [DEVICE_W-1:0] device;
        logic                nxt_valid;
        logic [IDX_W-1:0]    nxt;
    } t_entry;

    typedef struct packed {
        logic             re;
        logic             we;
        logic [BKT_W-1:0] addr;
        logic [IDX_W-1:0] wdata;
    } t_head_req;

    typedef struct packed {
        logic             re;
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           wdata;
    } t_pool_req;

    // modulus actually applied: zero acts as one, clamp to table size
    function automatic logic [BKT_W:0] eff_buckets(input logic [BCNT_W-1:0] cfg);
        logic [BKT_W:0] b;
        if (cfg == '0) begin
            b = (BKT_W+1)'(1);
        end else if (32'(cfg) > BUCKETS) begin
            b = (BKT_W+1)'(BUCKETS);
        end else begin
            b = (BKT_W+1)'(cfg);
        end
        return b;
    endfunction

    function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] cfg);
        logic [CNT_W-1:0] l;
        if (32'(cfg) > ENTRIES) begin
            l = CNT_W'(ENTRIES);
        end else begin
            l = CNT_W'(cfg);
        end
        return l;
    endfunction

endpackage

// ===== hdl/chsi_mod.sv =====
module chsi_mod (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [chsi_pkg::INODE_W-1:0]   i_dividend,
    input  logic [chsi_pkg::BKT_W:0]       i_divisor,
    output logic                           o_done,
    output logic [chsi_pkg::BKT_W-1:0]     o_rem
);

    logic [chsi_pkg::INODE_W-1:0] r_dvd;
    logic [chsi_pkg::BKT_W:0]     r_div;
    logic [chsi_pkg::BKT_W-1:0]   r_rem;
    logic [chsi_pkg::BKT_W-1:0]   n_rem;
    logic [chsi_pkg::MCNT_W-1:0]  r_cnt;
    logic                         r_run;
    logic                         r_done;

    // several restoring remainder steps per cycle, one dividend bit each
    always_comb begin
        logic [chsi_pkg::BKT_W-1:0] rem;
        logic [chsi_pkg::BKT_W:0]   t;
        rem = r_rem;
        t   = '0;
        for (int i = 0; i < chsi_pkg::MOD_STEP; i++) begin
            t = {rem, r_dvd[chsi_pkg::INODE_W-1-i]};
            if (t >= r_div) begin
                t = t - r_div;
            end
            rem = t[chsi_pkg::BKT_W-1:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == chsi_pkg::MCNT_W'(chsi_pkg::MOD_CYC - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= r_dvd << chsi_pkg::MOD_STEP;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/chsi_heads.sv =====
module chsi_heads (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  chsi_pkg::t_head_req         i_req,
    output logic                        o_valid,
    output logic [chsi_pkg::IDX_W-1:0]  o_head
);

    logic [chsi_pkg::IDX_W-1:0] r_mem [chsi_pkg::BUCKETS];
    logic [chsi_pkg::BUCKETS-1:0] r_valid;
    logic [chsi_pkg::IDX_W-1:0] r_q;
    logic                       r_vq;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vq    <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.re) begin
                r_vq <= r_valid[i_req.addr];
            end
        end
    end

    assign o_valid = r_vq;
    assign o_head  = r_q;

endmodule

// ===== hdl/chsi_pool.sv =====
module chsi_pool (
    input  logic                 i_clk,
    input  chsi_pkg::t_pool_req  i_req,
    output chsi_pkg::t_entry     o_entry
);

    chsi_pkg::t_entry r_mem [chsi_pkg::ENTRIES];
    chsi_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.addr];
        end
    end

    assign o_entry = r_q;

endmodule

// ===== hdl/chained_hash_set_insert.sv =====
// From the start transfer to the o_done strobe an insert steps through S_MOD (inode
// remainder unit), S_HRD, S_HEAD and S_WALK over any chain entries, then S_INS for an
// absent pair; a present pair ends in S_WALK. One insert at a time: busy is high while
// an item is in work and drops in the o_done cycle, so the next transfer lands at the
// edge ending it. Reset (synchronous, i_rst_n low) empties all buckets and the pool,
// restores bucket_count 256 and entry_limit 1024; the receiver cannot stall.
module chained_hash_set_insert (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [chsi_pkg::INODE_W-1:0]    i_inode_key,
    input  logic [chsi_pkg::DEVICE_W-1:0]   i_device_key,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_idx,
    input  logic [chsi_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic [chsi_pkg::USED_W-1:0]     o_entries_used
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MOD  = 6'b000010,
        S_HRD  = 6'b000100,
        S_HEAD = 6'b001000,
        S_WALK = 6'b010000,
        S_INS  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [chsi_pkg::BCNT_W-1:0]   r_bucket_count;
    logic [chsi_pkg::LIMIT_W-1:0]  r_entry_limit;
    logic [chsi_pkg::INODE_W-1:0]  r_ino;
    logic [chsi_pkg::DEVICE_W-1:0] r_dev;
    logic [chsi_pkg::BKT_W-1:0]    r_bucket;
    logic                          r_hvalid;
    logic [chsi_pkg::IDX_W-1:0]    r_head;
    logic [chsi_pkg::CNT_W-1:0]    r_used, n_used;
    logic                          r_done, n_done;
    chsi_pkg::t_status             r_status, n_status;

    logic                          accept;
    logic                          mod_done;
    logic [chsi_pkg::BKT_W-1:0]    mod_rem;
    logic                          head_valid;
    logic [chsi_pkg::IDX_W-1:0]    head_q;
    chsi_pkg::t_entry              entry_q;
    chsi_pkg::t_head_req           head_req;
    chsi_pkg::t_pool_req           pool_req;
    logic                          match;
    logic                          full;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign match  = (entry_q.inode == r_ino) && (entry_q.device == r_dev);
    assign full   = (r_used >= chsi_pkg::eff_limit(r_entry_limit));

    chsi_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (i_inode_key),
        .i_divisor  (chsi_pkg::eff_buckets(r_bucket_count)),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    chsi_heads u_heads (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (head_req),
        .o_valid (head_valid),
        .o_head  (head_q)
    );

    chsi_pool u_pool (
        .i_clk   (i_clk),
        .i_req   (pool_req),
        .o_entry (entry_q)
    );

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_done   = 1'b0;
        n_status = r_status;

        head_req       = '0;
        head_req.addr  = r_bucket;
        head_req.wdata = r_used[chsi_pkg::IDX_W-1:0];

        pool_req                 = '0;
        pool_req.addr            = head_q;
        pool_req.wdata.inode     = r_ino;
        pool_req.wdata.device    = r_dev;
        pool_req.wdata.nxt_valid = r_hvalid;
        pool_req.wdata.nxt       = r_head;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                head_req.re = 1'b1;
                n_state     = S_HEAD;
            end
            S_HEAD: begin
                if (head_valid) begin
                    pool_req.re = 1'b1;
                    n_state     = S_WALK;
                end else begin
                    n_state = S_INS;
                end
            end
            S_WALK: begin
                if (match) begin
                    n_status = chsi_pkg::ST_PRESENT;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (entry_q.nxt_valid) begin
                    pool_req.re   = 1'b1;
                    pool_req.addr = entry_q.nxt;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (full) begin
                    n_status = chsi_pkg::ST_FULL;
                end else begin
                    n_status      = chsi_pkg::ST_NEW;
                    head_req.we   = 1'b1;
                    pool_req.we   = 1'b1;
                    pool_req.addr = r_used[chsi_pkg::IDX_W-1:0];
                    n_used        = r_used + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_used         <= '0;
            r_done         <= 1'b0;
            r_status       <= chsi_pkg::ST_NEW;
            r_bucket_count <= chsi_pkg::BCNT_W'(chsi_pkg::BUCKETS);
            r_entry_limit  <= chsi_pkg::LIMIT_W'(chsi_pkg::ENTRIES);
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_done   <= n_done;
            r_status <= n_status;
            if (i_cfg_we) begin
                case (chsi_pkg::t_cfg_idx'(i_cfg_idx))
                    chsi_pkg::CFG_BUCKET_COUNT:
                        r_bucket_count <= i_cfg_data[chsi_pkg::BCNT_W-1:0];
                    chsi_pkg::CFG_ENTRY_LIMIT:
                        r_entry_limit <= i_cfg_data[chsi_pkg::LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ino <= i_inode_key;
            r_dev <= i_device_key;
        end
        if (r_state == S_MOD && mod_done) begin
            r_bucket <= mod_rem;
        end
        if (r_state == S_HEAD) begin
            r_hvalid <= head_valid;
            r_head   <= head_q;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_entries_used = chsi_pkg::USED_W'(r_used);

endmodule
